// File: rtl/cow_shadow_block_remap_unit_macros.svh
`ifndef COW_SHADOW_BLOCK_REMAP_UNIT_MACROS_SVH
`define COW_SHADOW_BLOCK_REMAP_UNIT_MACROS_SVH

// same-cycle implication
`define CSWR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CSWR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/cswr_pkg.sv
`default_nettype none

package cswr_pkg;

   localparam int MAP_DEPTH   = 1024;
   localparam int MAP_AW      = 10;
   localparam int MAP_WIDTH   = 10;
   localparam int BITMAP_WORD = 64;
   localparam int BM_DEPTH    = 4096;
   localparam int BM_AW       = 12;

   localparam logic [3:0]  MAX_SHIFT      = 4'd8;
   localparam logic [10:0] MAX_FILE_BANDS = 11'd1024;
   localparam logic [10:0] NO_BAND        = 11'h7FF;

   localparam logic [1:0] REG_BAND_SHIFT  = 2'd0;
   localparam logic [1:0] REG_FILE_SIZE   = 2'd1;
   localparam logic [1:0] REG_INIT_SHADOW = 2'd2;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BAND_RD,
      ST_BAND_EV,
      ST_WORD_RD,
      ST_WORD_EV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        func;
      logic [17:0] start_blk;
      logic [18:0] num_blks;
   } req_type;

   typedef struct packed {
      logic        from_shadow;
      logic        hw_raised;
      logic        range_error;
      logic [17:0] out_offset;
      logic [18:0] out_count;
      logic [18:0] shadow_size_blocks;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  band_shift;
      logic [10:0] file_bands;
      logic        hw_load;
      logic [10:0] hw_value;
   } cfg_type;

   typedef struct packed {
      logic                 we;
      logic [MAP_AW-1:0]    addr;
      logic [MAP_WIDTH-1:0] data;
   } map_wr_type;

   typedef struct packed {
      logic                   we;
      logic [BM_AW-1:0]       addr;
      logic [BITMAP_WORD-1:0] data;
   } bm_wr_type;

   typedef struct packed {
      logic       found;
      logic [5:0] idx;
   } ffs_type;

   function automatic ffs_type find_first(input logic [BITMAP_WORD-1:0] v);
      ffs_type r;
      r.found = |v;
      r.idx   = '0;
      for (int i = BITMAP_WORD - 1; i >= 0; i--) begin
         if (v[i]) begin
            r.idx = 6'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/cswr_ram.sv
`default_nettype none

module cswr_ram #(
   parameter int DEPTH = cswr_pkg::BM_DEPTH,
   parameter int WIDTH = cswr_pkg::BITMAP_WORD,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// File: rtl/cswr_core.sv
`default_nettype none

`include "cow_shadow_block_remap_unit_macros.svh"

module cswr_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire cswr_pkg::cfg_type                  cfg,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire cswr_pkg::req_type                  req_word,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output cswr_pkg::rsp_type                       rsp_word,
   output cswr_pkg::map_wr_type                    map_wr,
   output logic [cswr_pkg::MAP_AW-1:0]             map_raddr,
   input  wire logic [cswr_pkg::MAP_WIDTH-1:0]     map_rdata,
   output cswr_pkg::bm_wr_type                     bm_wr,
   output logic [cswr_pkg::BM_AW-1:0]              bm_raddr,
   input  wire logic [cswr_pkg::BITMAP_WORD-1:0]   bm_rdata
);

   cswr_pkg::state_type state_ff, state_in;
   logic [11:0] clr_ff, clr_in;
   logic        is_write_ff, is_write_in;
   logic [17:0] off_ff, off_in;
   logic [19:0] end_ff, end_in;
   logic        err_ff, err_in;
   logic [9:0]  band_ff, band_in;
   logic        first_ff, first_in;
   logic [9:0]  cur_ff, cur_in;
   logic [9:0]  startval_ff, startval_in;
   logic [19:0] bound_ff, bound_in;
   logic [19:0] limit_ff, limit_in;
   logic [11:0] word_ff, word_in;
   logic        wbit_ff, wbit_in;
   logic [10:0] nf_ff, nf_in;
   logic [10:0] fm_ff, fm_in;
   logic [10:0] hw_ff, hw_in;
   logic        rsp_valid_ff, rsp_valid_in;
   cswr_pkg::rsp_type rsp_ff, rsp_in;

   logic [3:0]  sh;
   logic [19:0] fsb, req_end;
   logic        req_err, accept, out_load;
   logic        hit_fm, mapped, alloc, band_ok, band_cut, band_more;
   logic [9:0]  band_val;
   logic [19:0] p_cur, p_next, piece_end;
   logic [19:0] lim_m1, word_base, re_raw, re_c;
   logic [11:0] last_word;
   logic        word_first, wbit, word_last_run;
   logic [5:0]  pos, hi;
   logic [63:0] set_mask, mism;
   cswr_pkg::ffs_type ff;
   logic [17:0] lowmask, shadow_off;
   logic        grew;
   logic [10:0] hw_new;

   // conditions
   always_comb begin
      sh        = cfg.band_shift;
      fsb       = 20'(cfg.file_bands) << sh;
      req_end   = 20'(req_word.start_blk) + 20'(req_word.num_blks);
      req_err   = (20'(req_word.start_blk) >= fsb) || (req_end > fsb);
      accept    = req_valid && req_ready;
      out_load  = !rsp_valid_ff || rsp_ready;

      hit_fm    = ({1'b0, band_ff} == fm_ff);
      mapped    = hit_fm || (map_rdata != '0);
      alloc     = is_write_ff && !mapped;
      band_ok   = mapped || is_write_ff;
      // unmapped band reads as zero on reads, takes the next free band on writes
      band_val  = hit_fm ? '0
                 : ((map_rdata != '0) ? map_rdata : (is_write_ff ? nf_ff[9:0] : '0));
      p_cur     = 20'(band_ff) << sh;
      p_next    = 20'({1'b0, band_ff} + 11'd1) << sh;
      band_cut  = first_ff ? !band_ok
                 : (!band_ok || (({1'b0, cur_ff} + 11'd1) != {1'b0, band_val}));
      band_more = !band_cut && (p_next < bound_ff);
      piece_end = band_cut ? (first_ff ? 20'(off_ff) : p_cur) : bound_ff;

      lim_m1     = limit_ff - 20'd1;
      last_word  = lim_m1[17:6];
      word_base  = 20'({word_ff, 6'd0});
      word_first = (word_ff == off_ff[17:6]);
      pos        = word_first ? off_ff[5:0] : 6'd0;
      hi         = (word_ff == last_word) ? lim_m1[5:0] : 6'd63;
      set_mask   = ({64{1'b1}} << pos) & ({64{1'b1}} >> (6'd63 - hi));

      wbit          = word_first ? bm_rdata[pos] : wbit_ff;
      mism          = (bm_rdata ^ {64{wbit}}) & ({64{1'b1}} << pos);
      ff            = cswr_pkg::find_first(mism);
      re_raw        = ff.found ? (word_base + 20'(ff.idx)) : (word_base + 20'd64);
      re_c          = (re_raw < end_ff) ? re_raw : end_ff;
      word_last_run = ff.found || ((word_base + 20'd64) >= end_ff);

      lowmask    = 18'((18'd1 << sh) - 18'd1);
      shadow_off = 18'(18'(startval_ff) << sh) + (off_ff & lowmask);
      grew       = !err_ff && is_write_ff && (nf_ff > hw_ff);
      hw_new     = grew ? nf_ff : hw_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cswr_pkg::ST_CLEAR: begin
            if (clr_ff == 12'hFFF) state_in = cswr_pkg::ST_IDLE;
         end
         cswr_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_err) state_in = cswr_pkg::ST_DONE;
               else if (req_word.func == cswr_pkg::FUNC_WRITE) state_in = cswr_pkg::ST_BAND_RD;
               else state_in = cswr_pkg::ST_WORD_RD;
            end
         end
         cswr_pkg::ST_BAND_RD: state_in = cswr_pkg::ST_BAND_EV;
         cswr_pkg::ST_BAND_EV: begin
            if (band_more) state_in = cswr_pkg::ST_BAND_RD;
            else if (is_write_ff && (piece_end != 20'(off_ff))) state_in = cswr_pkg::ST_WORD_RD;
            else state_in = cswr_pkg::ST_DONE;
         end
         cswr_pkg::ST_WORD_RD: state_in = cswr_pkg::ST_WORD_EV;
         cswr_pkg::ST_WORD_EV: begin
            if (is_write_ff) begin
               state_in = (word_ff == last_word) ? cswr_pkg::ST_DONE : cswr_pkg::ST_WORD_RD;
            end else if (word_last_run) begin
               state_in = wbit ? cswr_pkg::ST_BAND_RD : cswr_pkg::ST_DONE;
            end else begin
               state_in = cswr_pkg::ST_WORD_RD;
            end
         end
         cswr_pkg::ST_DONE: begin
            if (out_load) state_in = cswr_pkg::ST_IDLE;
         end
         default: state_in = cswr_pkg::ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ready = (state_ff == cswr_pkg::ST_IDLE);
      rsp_valid = rsp_valid_ff;
      rsp_word  = rsp_ff;
      map_raddr = band_ff;
      bm_raddr  = word_ff;
      map_wr.we   = 1'b0;
      map_wr.addr = band_ff;
      map_wr.data = nf_ff[9:0];
      bm_wr.we    = 1'b0;
      bm_wr.addr  = word_ff;
      bm_wr.data  = bm_rdata | set_mask;
      unique case (state_ff)
         cswr_pkg::ST_CLEAR: begin
            map_wr.we   = (clr_ff[11:10] == 2'd0);
            map_wr.addr = clr_ff[9:0];
            map_wr.data = '0;
            bm_wr.we    = 1'b1;
            bm_wr.addr  = clr_ff;
            bm_wr.data  = '0;
         end
         cswr_pkg::ST_BAND_EV: map_wr.we = alloc;
         cswr_pkg::ST_WORD_EV: bm_wr.we = is_write_ff;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      clr_in       = clr_ff;
      is_write_in  = is_write_ff;
      off_in       = off_ff;
      end_in       = end_ff;
      err_in       = err_ff;
      band_in      = band_ff;
      first_in     = first_ff;
      cur_in       = cur_ff;
      startval_in  = startval_ff;
      bound_in     = bound_ff;
      limit_in     = limit_ff;
      word_in      = word_ff;
      wbit_in      = wbit_ff;
      nf_in        = nf_ff;
      fm_in        = fm_ff;
      hw_in        = hw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         cswr_pkg::ST_CLEAR: clr_in = clr_ff + 12'd1;
         cswr_pkg::ST_IDLE: begin
            if (accept) begin
               is_write_in = req_word.func;
               off_in      = req_word.start_blk;
               end_in      = req_end;
               err_in      = req_err;
               band_in     = 10'(req_word.start_blk >> sh);
               first_in    = 1'b1;
               bound_in    = req_end;
               word_in     = req_word.start_blk[17:6];
            end
         end
         cswr_pkg::ST_BAND_EV: begin
            if (first_ff) startval_in = band_val;
            cur_in   = band_val;
            first_in = 1'b0;
            limit_in = piece_end;
            if (alloc) begin
               nf_in = nf_ff + 11'd1;
               if (nf_ff == 11'd0) fm_in = {1'b0, band_ff};
            end
            if (band_more) band_in = band_ff + 10'd1;
         end
         cswr_pkg::ST_WORD_EV: begin
            word_in = word_ff + 12'd1;
            if (!is_write_ff) begin
               wbit_in  = wbit;
               limit_in = re_c;
               bound_in = re_c;
            end
         end
         cswr_pkg::ST_DONE: begin
            if (out_load) begin
               rsp_valid_in          = 1'b1;
               rsp_in.range_error    = err_ff;
               rsp_in.from_shadow    = !err_ff && (is_write_ff || wbit_ff);
               rsp_in.hw_raised      = grew;
               rsp_in.out_offset     = err_ff ? '0
                                      : ((is_write_ff || wbit_ff) ? shadow_off : off_ff);
               rsp_in.out_count      = err_ff ? '0 : 19'(limit_ff - 20'(off_ff));
               rsp_in.shadow_size_blocks = 19'(19'(hw_new) << sh);
               hw_in                 = hw_new;
            end
         end
         default: ;
      endcase
      if (cfg.hw_load) hw_in = cfg.hw_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cswr_pkg::ST_CLEAR;
         clr_ff       <= '0;
         nf_ff        <= '0;
         fm_ff        <= cswr_pkg::NO_BAND;
         hw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         nf_ff        <= nf_in;
         fm_ff        <= fm_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_write_ff <= is_write_in;
      off_ff      <= off_in;
      end_ff      <= end_in;
      err_ff      <= err_in;
      band_ff     <= band_in;
      first_ff    <= first_in;
      cur_ff      <= cur_in;
      startval_ff <= startval_in;
      bound_ff    <= bound_in;
      limit_ff    <= limit_in;
      word_ff     <= word_in;
      wbit_ff     <= wbit_in;
      rsp_ff      <= rsp_in;
   end

   `CSWR_ASSERT_IMP(a_map_wr_src, map_wr.we, (state_ff == cswr_pkg::ST_CLEAR) || ((state_ff == cswr_pkg::ST_BAND_EV) && is_write_ff), "band map written outside clear or write lookup")
   `CSWR_ASSERT_IMP(a_limit_range, (state_ff == cswr_pkg::ST_DONE) && !err_ff, (limit_ff >= 20'(off_ff)) && (limit_ff <= end_ff), "piece limit outside request")
   `CSWR_ASSERT_NXT(a_hw_follows, (state_ff == cswr_pkg::ST_DONE) && out_load && grew, hw_ff == nf_ff, "high-water mark not raised to next free band")

endmodule

`default_nettype wire

// File: rtl/cow_shadow_block_remap_unit.sv
// order: a read scans the bitmap words of the run, then checks bands (shadow runs only);
//   a write maps bands, then marks bitmap words; range errors go straight to the result
// one request in flight; each band lookup and each bitmap word passes a read and an evaluate
//   state on its memory; the result register frees the input side
// reset: clearing pass of both memories with req_ready low; registers reset to
//   band_shift 8, file_size_bands 1024, initial_shadow_bands 0
`default_nettype none

module cow_shadow_block_remap_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cswr_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output cswr_pkg::rsp_type      rsp_word,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [3:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic [3:0]  shift_ff, shift_in;
   logic [10:0] fsize_ff, fsize_in;
   logic [10:0] init_ff, init_in;
   logic        wr_en;
   cswr_pkg::cfg_type cfg;

   cswr_pkg::map_wr_type                 map_wr;
   logic [cswr_pkg::MAP_AW-1:0]          map_raddr;
   logic [cswr_pkg::MAP_WIDTH-1:0]       map_rdata;
   cswr_pkg::bm_wr_type                  bm_wr;
   logic [cswr_pkg::BM_AW-1:0]           bm_raddr;
   logic [cswr_pkg::BITMAP_WORD-1:0]     bm_rdata;

   always_comb begin
      pready   = 1'b1;
      wr_en    = psel && penable && pwrite;
      shift_in = shift_ff;
      fsize_in = fsize_ff;
      init_in  = init_ff;
      cfg.hw_load  = 1'b0;
      cfg.hw_value = pwdata[10:0];
      prdata   = '0;
      unique case (paddr[3:2])
         cswr_pkg::REG_BAND_SHIFT: begin
            prdata = 32'(shift_ff);
            if (wr_en) shift_in = pwdata[3:0];
         end
         cswr_pkg::REG_FILE_SIZE: begin
            prdata = 32'(fsize_ff);
            if (wr_en) fsize_in = pwdata[10:0];
         end
         cswr_pkg::REG_INIT_SHADOW: begin
            prdata = 32'(init_ff);
            if (wr_en) begin
               init_in     = pwdata[10:0];
               cfg.hw_load = 1'b1;
            end
         end
         default: ;
      endcase
      cfg.band_shift = (shift_ff > cswr_pkg::MAX_SHIFT) ? cswr_pkg::MAX_SHIFT : shift_ff;
      cfg.file_bands = (fsize_ff > cswr_pkg::MAX_FILE_BANDS) ? cswr_pkg::MAX_FILE_BANDS
                       : fsize_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 4'd8;
         fsize_ff <= cswr_pkg::MAX_FILE_BANDS;
         init_ff  <= '0;
      end else begin
         shift_ff <= shift_in;
         fsize_ff <= fsize_in;
         init_ff  <= init_in;
      end
   end

   cswr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .map_wr    (map_wr),
      .map_raddr (map_raddr),
      .map_rdata (map_rdata),
      .bm_wr     (bm_wr),
      .bm_raddr  (bm_raddr),
      .bm_rdata  (bm_rdata)
   );

   cswr_ram #(
      .DEPTH (cswr_pkg::MAP_DEPTH),
      .WIDTH (cswr_pkg::MAP_WIDTH)
   ) u_band_map (
      .clock (clock),
      .we    (map_wr.we),
      .waddr (map_wr.addr),
      .wdata (map_wr.data),
      .raddr (map_raddr),
      .rdata (map_rdata)
   );

   cswr_ram #(
      .DEPTH (cswr_pkg::BM_DEPTH),
      .WIDTH (cswr_pkg::BITMAP_WORD)
   ) u_written_map (
      .clock (clock),
      .we    (bm_wr.we),
      .waddr (bm_wr.addr),
      .wdata (bm_wr.data),
      .raddr (bm_raddr),
      .rdata (bm_rdata)
   );

endmodule

`default_nettype wire
